// ===== design/biq_pkg.sv =====
`timescale 1ns / 1ps

package biq_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int COEF_W         = 19;
  localparam int GAIN_W         = 17;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int OUT_W          = 32;

  // Datapath widths: one shared 32 x 19 signed multiplier, 64-bit accumulator
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 19;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 64;
  // The gain product is split at this bit into a low and a high partial product
  localparam int LO_W    = 24;

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Register reset values
  localparam logic [COEF_W-1:0] B0_RESET   = COEF_W'(65536);
  localparam logic [COEF_W-1:0] B1_RESET   = COEF_W'(-131072);
  localparam logic [COEF_W-1:0] B2_RESET   = COEF_W'(65536);
  localparam logic [COEF_W-1:0] A1_RESET   = COEF_W'(-130958);
  localparam logic [COEF_W-1:0] A2_RESET   = COEF_W'(65422);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  // Register map, index = paddr / 4
  typedef enum logic [2:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GAIN = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] b0;
    logic [COEF_W-1:0] b1;
    logic [COEF_W-1:0] b2;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [GAIN_W-1:0] gain;
  } coef_t;

  // Microcode
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_INPUT,
    WAIT_OUTPUT
  } wait_t;

  typedef enum logic [2:0] {
    A_IN,
    A_X1,
    A_X2,
    A_Y1,
    A_Y2,
    A_LO,
    A_HI
  } a_sel_t;

  typedef enum logic [2:0] {
    B_B0,
    B_B1,
    B_B2,
    B_A1,
    B_A2,
    B_GAIN
  } b_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    wait_t   wait_on;
    logic    commit;
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    logic    latch_hi;
    step_t   next;
  } ucode_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } seq_status_t;

endpackage

// ===== design/biq_cfg_regs.sv =====
`timescale 1ns / 1ps

module biq_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [biq_pkg::PADDR_W-1:0]   paddr,
  input  logic [biq_pkg::PDATA_W-1:0]   pwdata,
  output logic [biq_pkg::PDATA_W-1:0]   prdata,
  output biq_pkg::coef_t                coef
);

  biq_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx   = biq_pkg::reg_idx_t'(paddr[biq_pkg::PADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  // Register writes; addresses past the map are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0   <= biq_pkg::B0_RESET;
      coef.b1   <= biq_pkg::B1_RESET;
      coef.b2   <= biq_pkg::B2_RESET;
      coef.a1   <= biq_pkg::A1_RESET;
      coef.a2   <= biq_pkg::A2_RESET;
      coef.gain <= biq_pkg::GAIN_RESET;
    end else if (wr_en) begin
      case (idx)
        biq_pkg::REG_B0:   coef.b0   <= pwdata[biq_pkg::COEF_W-1:0];
        biq_pkg::REG_B1:   coef.b1   <= pwdata[biq_pkg::COEF_W-1:0];
        biq_pkg::REG_B2:   coef.b2   <= pwdata[biq_pkg::COEF_W-1:0];
        biq_pkg::REG_A1:   coef.a1   <= pwdata[biq_pkg::COEF_W-1:0];
        biq_pkg::REG_A2:   coef.a2   <= pwdata[biq_pkg::COEF_W-1:0];
        biq_pkg::REG_GAIN: coef.gain <= pwdata[biq_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, coefficients sign-extended
  always_comb begin
    case (idx)
      biq_pkg::REG_B0:   prdata = biq_pkg::PDATA_W'($signed(coef.b0));
      biq_pkg::REG_B1:   prdata = biq_pkg::PDATA_W'($signed(coef.b1));
      biq_pkg::REG_B2:   prdata = biq_pkg::PDATA_W'($signed(coef.b2));
      biq_pkg::REG_A1:   prdata = biq_pkg::PDATA_W'($signed(coef.a1));
      biq_pkg::REG_A2:   prdata = biq_pkg::PDATA_W'($signed(coef.a2));
      biq_pkg::REG_GAIN: prdata = biq_pkg::PDATA_W'(coef.gain);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== design/biq_ucode_rom.sv =====
`timescale 1ns / 1ps

module biq_ucode_rom (
  input  biq_pkg::step_t  step,
  output biq_pkg::ucode_t uc
);

  // Program: the multiplier output is registered, so each step that updates
  // the accumulator uses the product issued by the step before it.
  always_comb begin
    case (step)
      // wait for a sample, issue x * b0 straight from the input bus
      biq_pkg::step_t'(0): uc = '{biq_pkg::WAIT_INPUT, 1'b0, biq_pkg::A_IN,
                                  biq_pkg::B_B0, biq_pkg::ACC_HOLD, 1'b0,
                                  biq_pkg::step_t'(1)};
      biq_pkg::step_t'(1): uc = '{biq_pkg::WAIT_NONE, 1'b0, biq_pkg::A_X1,
                                  biq_pkg::B_B1, biq_pkg::ACC_LOAD, 1'b0,
                                  biq_pkg::step_t'(2)};
      biq_pkg::step_t'(2): uc = '{biq_pkg::WAIT_NONE, 1'b0, biq_pkg::A_X2,
                                  biq_pkg::B_B2, biq_pkg::ACC_ADD, 1'b0,
                                  biq_pkg::step_t'(3)};
      biq_pkg::step_t'(3): uc = '{biq_pkg::WAIT_NONE, 1'b0, biq_pkg::A_Y1,
                                  biq_pkg::B_A1, biq_pkg::ACC_ADD, 1'b0,
                                  biq_pkg::step_t'(4)};
      biq_pkg::step_t'(4): uc = '{biq_pkg::WAIT_NONE, 1'b0, biq_pkg::A_Y2,
                                  biq_pkg::B_A2, biq_pkg::ACC_SUB, 1'b0,
                                  biq_pkg::step_t'(5)};
      // last feedback term; multiplier idle
      biq_pkg::step_t'(5): uc = '{biq_pkg::WAIT_NONE, 1'b0, biq_pkg::A_LO,
                                  biq_pkg::B_GAIN, biq_pkg::ACC_SUB, 1'b0,
                                  biq_pkg::step_t'(6)};
      // low part of scaled sum times gain, keep the high part
      biq_pkg::step_t'(6): uc = '{biq_pkg::WAIT_NONE, 1'b0, biq_pkg::A_LO,
                                  biq_pkg::B_GAIN, biq_pkg::ACC_HOLD, 1'b1,
                                  biq_pkg::step_t'(7)};
      biq_pkg::step_t'(7): uc = '{biq_pkg::WAIT_NONE, 1'b0, biq_pkg::A_HI,
                                  biq_pkg::B_GAIN, biq_pkg::ACC_LOAD, 1'b0,
                                  biq_pkg::step_t'(8)};
      biq_pkg::step_t'(8): uc = '{biq_pkg::WAIT_NONE, 1'b0, biq_pkg::A_HI,
                                  biq_pkg::B_GAIN, biq_pkg::ACC_ADD_HI, 1'b0,
                                  biq_pkg::step_t'(9)};
      // wait for the output register, then write result and history
      biq_pkg::step_t'(9): uc = '{biq_pkg::WAIT_OUTPUT, 1'b1, biq_pkg::A_HI,
                                  biq_pkg::B_GAIN, biq_pkg::ACC_HOLD, 1'b0,
                                  biq_pkg::step_t'(0)};
      default:             uc = '{biq_pkg::WAIT_NONE, 1'b0, biq_pkg::A_HI,
                                  biq_pkg::B_GAIN, biq_pkg::ACC_HOLD, 1'b0,
                                  biq_pkg::step_t'(0)};
    endcase
  end

endmodule

// ===== design/biq_sequencer.sv =====
`timescale 1ns / 1ps

module biq_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  biq_pkg::seq_status_t status,
  output biq_pkg::ucode_t      uc
);

  biq_pkg::step_t step;
  biq_pkg::step_t step_next;
  logic           hold;

  biq_ucode_rom u_rom (
    .step (step),
    .uc   (uc)
  );

  // A waiting step jumps to itself until its condition clears
  always_comb begin
    case (uc.wait_on)
      biq_pkg::WAIT_INPUT:  hold = !status.in_valid;
      biq_pkg::WAIT_OUTPUT: hold = status.out_busy;
      default:              hold = 1'b0;
    endcase
    step_next = hold ? step : uc.next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== design/biq_datapath.sv =====
`timescale 1ns / 1ps

module biq_datapath #(
  parameter int SAMPLE_WIDTH   = biq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  biq_pkg::ucode_t             uc,
  input  biq_pkg::coef_t              coef,
  input  logic                        in_valid,
  input  logic [SAMPLE_WIDTH-1:0]     in_sample,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [biq_pkg::OUT_W-1:0]   out_sample,
  output biq_pkg::seq_status_t        status
);

  localparam logic signed [biq_pkg::ACC_W-1:0] OutMax = biq_pkg::ACC_W'(64'sd2147483647);
  localparam logic signed [biq_pkg::ACC_W-1:0] OutMin = -biq_pkg::ACC_W'(64'sd2147483648);

  // History
  logic signed [SAMPLE_WIDTH-1:0]    x;
  logic signed [SAMPLE_WIDTH-1:0]    x1;
  logic signed [SAMPLE_WIDTH-1:0]    x2;
  logic signed [biq_pkg::OUT_W-1:0]  y1;
  logic signed [biq_pkg::OUT_W-1:0]  y2;

  // Arithmetic
  logic signed [biq_pkg::MUL_A_W-1:0] mul_a;
  logic signed [biq_pkg::MUL_B_W-1:0] mul_b;
  logic signed [biq_pkg::PROD_W-1:0]  prod;
  logic signed [biq_pkg::ACC_W-1:0]   acc;
  logic signed [biq_pkg::ACC_W-1:0]   acc_next;
  logic signed [biq_pkg::ACC_W-1:0]   scaled;
  logic signed [biq_pkg::ACC_W-1:0]   scaled_hi;
  logic signed [biq_pkg::MUL_A_W-1:0] hi;
  logic signed [biq_pkg::ACC_W-1:0]   yq;
  logic signed [biq_pkg::OUT_W-1:0]   ysat;

  logic in_fire;
  logic commit_en;

  assign status.in_valid  = in_valid;
  assign status.out_busy  = out_valid && !out_ready;
  assign in_fire          = (uc.wait_on == biq_pkg::WAIT_INPUT) && in_valid;
  assign commit_en        = uc.commit && !status.out_busy;

  // Sum scaled back from coefficient format, split for the gain product
  assign scaled    = acc >>> COEF_FRAC_BITS;
  assign scaled_hi = scaled >>> biq_pkg::LO_W;

  // Operand select
  always_comb begin
    case (uc.a_sel)
      biq_pkg::A_IN: mul_a = biq_pkg::MUL_A_W'($signed(in_sample));
      biq_pkg::A_X1: mul_a = biq_pkg::MUL_A_W'(x1);
      biq_pkg::A_X2: mul_a = biq_pkg::MUL_A_W'(x2);
      biq_pkg::A_Y1: mul_a = y1;
      biq_pkg::A_Y2: mul_a = y2;
      biq_pkg::A_LO: mul_a = {{(biq_pkg::MUL_A_W - biq_pkg::LO_W){1'b0}},
                              scaled[biq_pkg::LO_W-1:0]};
      biq_pkg::A_HI: mul_a = hi;
      default:       mul_a = '0;
    endcase
    case (uc.b_sel)
      biq_pkg::B_B0:   mul_b = coef.b0;
      biq_pkg::B_B1:   mul_b = coef.b1;
      biq_pkg::B_B2:   mul_b = coef.b2;
      biq_pkg::B_A1:   mul_b = coef.a1;
      biq_pkg::B_A2:   mul_b = coef.a2;
      biq_pkg::B_GAIN: mul_b = {{(biq_pkg::MUL_B_W - biq_pkg::GAIN_W){1'b0}}, coef.gain};
      default:         mul_b = '0;
    endcase
  end

  // Accumulator update from the product of the previous step
  always_comb begin
    case (uc.acc_op)
      biq_pkg::ACC_LOAD:   acc_next = biq_pkg::ACC_W'(prod);
      biq_pkg::ACC_ADD:    acc_next = acc + biq_pkg::ACC_W'(prod);
      biq_pkg::ACC_SUB:    acc_next = acc - biq_pkg::ACC_W'(prod);
      biq_pkg::ACC_ADD_HI: acc_next = acc + (biq_pkg::ACC_W'(prod) <<< biq_pkg::LO_W);
      default:             acc_next = acc;
    endcase
  end

  // Final gain shift and saturation to 32 bits
  always_comb begin
    yq = acc >>> biq_pkg::GAIN_FRAC_BITS;
    if (yq > OutMax) begin
      ysat = {1'b0, {(biq_pkg::OUT_W-1){1'b1}}};
    end else if (yq < OutMin) begin
      ysat = {1'b1, {(biq_pkg::OUT_W-1){1'b0}}};
    end else begin
      ysat = yq[biq_pkg::OUT_W-1:0];
    end
  end

  // Multiplier, accumulator, split register, input sample and output register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    acc  <= acc_next;
    if (uc.latch_hi) begin
      hi <= scaled_hi[biq_pkg::MUL_A_W-1:0];
    end
    if (in_fire) begin
      x <= in_sample;
    end
    if (commit_en) begin
      out_sample <= ysat;
    end
  end

  // History and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      x1        <= '0;
      x2        <= '0;
      y1        <= '0;
      y2        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit_en) begin
        x2        <= x1;
        x1        <= x;
        y2        <= y1;
        y1        <= ysat;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/biquad_iir_q16_filter.sv =====
`timescale 1ns / 1ps

// Second-order direct-form-I IIR filter. Each input item is one signed sample;
// the block forms b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 exactly in a 64-bit
// accumulator, floors it by COEF_FRAC_BITS, applies the unsigned Q16 gain
// (65536 is unity), floors by 16 and saturates to 32-bit signed. The result is
// also the newest output history value. Coefficients are signed 19-bit Q16
// registers at byte addresses 0 (b0), 4 (b1), 8 (b2), 12 (a1), 16 (a2); the
// gain is at 20; write them only while no sample is in flight. A small
// microcode program issues five coefficient products and two gain partial
// products through a single 32 x 19 multiplier. A new sample is taken only
// after the previous result is in the output register, and that write
// waits while the output side is stalled. History registers reset to zero.
module biquad_iir_q16_filter #(
  parameter int SAMPLE_WIDTH   = biq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF,
  localparam int InTdataW      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [biq_pkg::PADDR_W-1:0] paddr,
  input  logic [biq_pkg::PDATA_W-1:0] pwdata,
  output logic [biq_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [InTdataW-1:0]         s_axis_tdata,   // sample_in, zero pad above
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [biq_pkg::OUT_W-1:0]   m_axis_tdata    // sample_out
);

  biq_pkg::coef_t       coef;
  biq_pkg::ucode_t      uc;
  biq_pkg::seq_status_t status;

  assign pready        = 1'b1;
  assign s_axis_tready = (uc.wait_on == biq_pkg::WAIT_INPUT);

  biq_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .coef    (coef)
  );

  biq_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uc     (uc)
  );

  biq_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .uc         (uc),
    .coef       (coef),
    .in_valid   (s_axis_tvalid),
    .in_sample  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_sample (m_axis_tdata),
    .status     (status)
  );

endmodule

// ===== tb/tb_biquad_iir_q16_filter.sv =====
`timescale 1ns / 1ps

module tb_biquad_iir_q16_filter;
  import biq_pkg::*;

  localparam int SAMPLE_W      = SAMPLE_WIDTH_DEF;
  localparam int FRAC_BITS     = COEF_FRAC_BITS_DEF;
  localparam int NUM_REGS      = 6;
  localparam int LATENCY       = 10;
  localparam int SETTLE_CYCLES = 2 * LATENCY;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 105;
  localparam int NUM_PHASES    = 8;
  localparam int MAX_PRINTS    = 40;

  localparam longint OUT_MAX = 64'sd2147483647;
  localparam longint OUT_MIN = -64'sd2147483648;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]    result_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // impulse-like and full-swing inputs for the reset-time coefficients
  localparam sample_t HP_SWEEP[8] = '{
    sample_t'(0), sample_t'(1), sample_t'(-1), SAMPLE_MAX,
    SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, sample_t'(0)
  };

  // Filter predictor plus queue of outstanding filtered samples
  class biquad_scoreboard;
    logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;
    logic [GAIN_W-1:0]        gain;
    sample_t                  x_prev1, x_prev2;
    result_t                  y_prev1, y_prev2;
    result_t                  expected_q[$];
    int                       mismatches;
    int                       matched;

    function new();
      b0 = B0_RESET;
      b1 = B1_RESET;
      b2 = B2_RESET;
      a1 = A1_RESET;
      a2 = A2_RESET;
      gain = GAIN_RESET;
      x_prev1 = '0;
      x_prev2 = '0;
      y_prev1 = '0;
      y_prev2 = '0;
      mismatches = 0;
      matched = 0;
    endfunction

    // out-of-range indexes are dropped; stray upper bits are cut off
    function void write_reg(logic [2:0] idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_B0:   b0 = value[COEF_W-1:0];
        REG_B1:   b1 = value[COEF_W-1:0];
        REG_B2:   b2 = value[COEF_W-1:0];
        REG_A1:   a1 = value[COEF_W-1:0];
        REG_A2:   a2 = value[COEF_W-1:0];
        REG_GAIN: gain = value[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PDATA_W-1:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_B0:   return PDATA_W'(unsigned'(b0));
        REG_B1:   return PDATA_W'(unsigned'(b1));
        REG_B2:   return PDATA_W'(unsigned'(b2));
        REG_A1:   return PDATA_W'(unsigned'(a1));
        REG_A2:   return PDATA_W'(unsigned'(a2));
        REG_GAIN: return PDATA_W'(gain);
        default:  return '0;
      endcase
    endfunction

    // Direct form I step: exact sum, floor by the coefficient scale,
    // gain, floor again, clamp to 32 bits
    function void note_sample(sample_t x);
      longint acc;
      longint scaled;
      acc = longint'(b0) * longint'(x) + longint'(b1) * longint'(x_prev1)
          + longint'(b2) * longint'(x_prev2) - longint'(a1) * longint'(y_prev1)
          - longint'(a2) * longint'(y_prev2);
      scaled = acc >>> FRAC_BITS;
      scaled = (scaled * longint'(gain)) >>> GAIN_FRAC_BITS;
      if (scaled > OUT_MAX) scaled = OUT_MAX;
      if (scaled < OUT_MIN) scaled = OUT_MIN;
      x_prev2 = x_prev1;
      x_prev1 = x;
      y_prev2 = y_prev1;
      y_prev1 = result_t'(scaled);
      expected_q.push_back(y_prev1);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("output %0d with no sample outstanding", got));
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        report($sformatf("sample_out %0d, predicted %0d", got, want));
      end else begin
        matched++;
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [SAMPLE_W-1:0]  s_axis_tdata = '0;   // sample_in
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;        // sample_out

  biquad_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  biquad_iir_q16_filter #(
    .SAMPLE_WIDTH  (SAMPLE_W),
    .COEF_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Output side: check results, random backpressure, idle counter
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // One bus transfer: setup phase, access phase until pready, then idle
  task automatic reg_access(logic [2:0] idx, logic wr, logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write, then for a mapped register read back and compare the implemented bits
  task automatic write_register(logic [2:0] idx, logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    logic [PDATA_W-1:0] mask;
    reg_access(idx, 1'b1, value, rd);
    sb.write_reg(idx, value);
    if (idx < NUM_REGS) begin
      reg_access(idx, 1'b0, '0, rd);
      mask = (idx == REG_GAIN) ? PDATA_W'((1 << GAIN_W) - 1) : PDATA_W'((1 << COEF_W) - 1);
      if ((rd & mask) !== sb.reg_value(idx)) begin
        sb.report($sformatf("register %0d reads 0x%h, wrote 0x%h", idx, rd, value));
      end
    end
  endtask

  task automatic load_coefs(int b0, int b1, int b2, int a1, int a2, int gain);
    write_register(REG_B0, b0);
    write_register(REG_B1, b1);
    write_register(REG_B2, b2);
    write_register(REG_A1, a1);
    write_register(REG_A2, a2);
    write_register(REG_GAIN, gain);
  endtask

  // Returns at the edge where the sample was taken, tvalid still high
  task automatic send_sample(sample_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= x;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_sample(x);
  endtask

  // Let every outstanding result come out, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pacing(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  // Mix of full-scale noise, low-level noise, rail values and zero
  function automatic sample_t random_sample();
    int small_val;
    small_val = int'($urandom_range(1023)) - 512;
    case ($urandom_range(3))
      0, 1: return sample_t'($urandom());
      2: return sample_t'(small_val);
      default: begin
        case ($urandom_range(2))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          default: return sample_t'(0);
        endcase
      end
    endcase
  endfunction

  task automatic configure_phase(int p);
    case (p)
      0: load_coefs(65536, -131072, 65536, -131015, 65478, 65536);
      1: load_coefs(16384, 32768, 16384, -26508, 13149, 65536);
      2: load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      3: load_coefs(16384, 32768, 16384, -26508, 13149, 131071);
      4: load_coefs(65536, -131072, 65536, -130958, 65422, $urandom_range(131071));
      5: load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 0);
      6: load_coefs(-262144, 262143, -262144, 262143, -262144, 65536);
      default: load_coefs(24947, 69944, 24947, -26508, 13149, 40108);
    endcase
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset-time coefficients: impulses and full swings
    set_pacing(0);
    foreach (HP_SWEEP[i]) send_sample(HP_SWEEP[i]);
    drain();

    // runaway feedback with gain above unity, stray upper bits in the writes,
    // and writes to unmapped addresses; drives both saturation rails
    load_coefs(32'hFFFB_FFFF, 0, 0, 262143, 0, 32'h5A5F_FFFF);
    write_register(3'(NUM_REGS), 32'h1234_5678);
    write_register(3'(NUM_REGS + 1), 32'hFFFF_FFFF);
    repeat (8) send_sample(SAMPLE_MAX);
    repeat (2) send_sample(SAMPLE_MIN);
    drain();

    // random phases, each with its own coefficients and pacing
    for (int p = 0; p < NUM_PHASES; p++) begin
      configure_phase(p);
      set_pacing(p % 4);
      repeat (PHASE_ITEMS) send_sample(random_sample());
      drain();
    end

    $display("checked %0d filtered samples over %0d coefficient sets,", sb.matched,
             NUM_PHASES + 2);
    $display("incl. saturation, zero gain and stalls on both stream sides");
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
